// ===== rtl/sensor_matrix_scan_controller_core_assert.svh =====
// Assertion macros shared by the scan controller modules
`ifndef SENSOR_MATRIX_SCAN_CONTROLLER_CORE_ASSERT_SVH
`define SENSOR_MATRIX_SCAN_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SMSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/smsc_pkg.sv =====
// Shared constants, operation codes and controller/datapath signal groups
package smsc_pkg;

  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxCols    = 16;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned StoreDepth = 256;
  localparam int unsigned IdxBits    = 8;
  localparam int unsigned DimBits    = 5;

  localparam logic [15:0] SampleMask = 16'((32'd1 << SampleBits) - 32'd1);
  localparam logic [7:0]  LenStep    = 8'hFF;

  localparam logic [2:0] OpStart    = 3'd0;
  localparam logic [2:0] OpTick     = 3'd1;
  localparam logic [2:0] OpStop     = 3'd2;
  localparam logic [2:0] OpReadHdr  = 3'd3;
  localparam logic [2:0] OpReadCell = 3'd4;
  localparam logic [2:0] OpReadTime = 3'd5;
  localparam logic [2:0] OpLoadOrd  = 3'd6;

  localparam logic [2:0] CfgNumRows  = 3'd0;
  localparam logic [2:0] CfgNumCols  = 3'd1;
  localparam logic [2:0] CfgFirstRow = 3'd2;
  localparam logic [2:0] CfgFirstCol = 3'd3;
  localparam logic [2:0] CfgUseOrder = 3'd4;
  localparam logic [2:0] CfgOrderLen = 3'd5;
  localparam logic [2:0] CfgModeByte = 3'd6;

  typedef struct packed {
    logic       cap;
    logic       do_start;
    logic       do_tick;
    logic       do_stop;
    logic       do_hdr;
    logic       do_time;
    logic       do_load;
    logic       cur_from_ord;
    logic       cell_begin;
    logic       cell_from_ord;
    logic       cell_from_div;
    logic       cell_fin;
    logic       emit;
    logic       blank;
    logic       last;
    logic [1:0] idx;
  } smsc_cmd_t;

  typedef struct packed {
    logic       use_order;
    logic       active;
    logic [1:0] nbm1;
    logic       div_done;
  } smsc_sts_t;

endpackage

// ===== rtl/smsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for raster cell positions
module smsc_div import smsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [IdxBits-1:0] dividend_i,
  input  logic [DimBits-1:0] divisor_i,
  output logic               done_o,
  output logic [IdxBits-1:0] quot_o,
  output logic [3:0]         rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [2:0]         cnt_q;
  logic [IdxBits-1:0] dvd_q;
  logic [DimBits-1:0] rem_q;
  logic [DimBits:0]   trial;
  logic [DimBits:0]   dsr;
  logic               ge;

  assign dsr   = {1'b0, divisor_i};
  assign trial = {rem_q, dvd_q[IdxBits-1]};
  assign ge    = (trial >= dsr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'(IdxBits - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DimBits'(trial - dsr) : trial[DimBits-1:0];
      dvd_q <= {dvd_q[IdxBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q[3:0];

endmodule

// ===== rtl/smsc_datapath.sv =====
// Scan datapath: settings, scan position, frame store, order table and result registers
`include "sensor_matrix_scan_controller_core_assert.svh"
module smsc_datapath import smsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  smsc_cmd_t   cmd_i,
  output smsc_sts_t   sts_o,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output logic        cfg_ready_o,
  input  logic [15:0] sample_i,
  input  logic [31:0] current_time_i,
  input  logic [7:0]  order_index_i,
  input  logic [3:0]  order_row_i,
  input  logic [3:0]  order_col_i,
  output logic        result_valid_o,
  output logic [3:0]  mux_row_o,
  output logic [3:0]  mux_col_o,
  output logic        scanning_o,
  output logic        frame_done_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_o
);

  logic [4:0]  num_rows_q;
  logic [4:0]  num_cols_q;
  logic [3:0]  first_row_q;
  logic [3:0]  first_col_q;
  logic        use_order_q;
  logic [8:0]  order_len_q;
  logic [7:0]  mode_byte_q;

  logic [15:0] smp_q;
  logic [31:0] time_q;
  logic [7:0]  oidx_q;
  logic [3:0]  orow_q;
  logic [3:0]  ocol_q;

  logic [3:0]  cur_row_q;
  logic [3:0]  cur_col_q;
  logic [7:0]  scan_idx_q;
  logic [7:0]  rd_ptr_q;
  logic        active_q;
  logic        complete_q;
  logic [31:0] stamp_q;

  logic [7:0]  byte_q [4];
  logic [1:0]  nbm1_q;

  logic [7:0]  ord_mem [StoreDepth];
  logic [7:0]  ord_rdata_q;
  logic        ord_re;
  logic [7:0]  ord_raddr;

  logic [15:0] fs_mem [StoreDepth];
  logic [StoreDepth-1:0] fs_vld_q;
  logic [15:0] fs_rdata_q;
  logic        fs_rvld_q;
  logic        fs_we;
  logic [7:0]  fs_waddr;
  logic        fs_re;
  logic [7:0]  fs_raddr;
  logic [15:0] cell_val;

  logic [4:0]  eff_rows;
  logic [4:0]  eff_cols;
  logic [8:0]  eff_len;
  logic [9:0]  raster_cnt;
  logic [8:0]  cell_cnt;
  logic [9:0]  hdr_len;
  logic [31:0] elapsed;

  logic [8:0]  ord_nxt;
  logic        ord_end;
  logic [7:0]  tick_idx;
  logic        col_wrap;
  logic        row_wrap;

  logic [7:0]  p_clamp;
  logic [8:0]  p_nxt;
  logic [7:0]  rd_ptr_nxt;

  logic        div_done;
  logic [7:0]  div_quot;
  logic [3:0]  div_rem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= 5'(MaxRows);
      num_cols_q  <= 5'(MaxCols);
      first_row_q <= '0;
      first_col_q <= '0;
      use_order_q <= 1'b0;
      order_len_q <= 9'(StoreDepth);
      mode_byte_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgNumRows:  num_rows_q  <= cfg_data_i[4:0];
        CfgNumCols:  num_cols_q  <= cfg_data_i[4:0];
        CfgFirstRow: first_row_q <= cfg_data_i[3:0];
        CfgFirstCol: first_col_q <= cfg_data_i[3:0];
        CfgUseOrder: use_order_q <= cfg_data_i[0];
        CfgOrderLen: order_len_q <= cfg_data_i;
        CfgModeByte: mode_byte_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_rows_q == '0) eff_rows = 5'd1;
    else if (num_rows_q > 5'(MaxRows)) eff_rows = 5'(MaxRows);
    else eff_rows = num_rows_q;
    if (num_cols_q == '0) eff_cols = 5'd1;
    else if (num_cols_q > 5'(MaxCols)) eff_cols = 5'(MaxCols);
    else eff_cols = num_cols_q;
    if (order_len_q == '0) eff_len = 9'd1;
    else if (order_len_q > 9'(StoreDepth)) eff_len = 9'(StoreDepth);
    else eff_len = order_len_q;
  end

  assign raster_cnt = {5'b0, eff_rows} * {5'b0, eff_cols};
  assign cell_cnt   = use_order_q ? eff_len : raster_cnt[8:0];
  assign hdr_len    = {cell_cnt, 1'b0} + 10'd4;
  assign elapsed    = time_q - stamp_q;

  assign ord_nxt  = {1'b0, scan_idx_q} + 9'd1;
  assign ord_end  = (ord_nxt >= eff_len);
  assign tick_idx = ord_end ? '0 : ord_nxt[7:0];
  assign col_wrap = (({1'b0, cur_col_q}) + 5'd1 >= eff_cols);
  assign row_wrap = (({1'b0, cur_row_q}) + 5'd1 >= eff_rows);

  assign p_clamp    = ({1'b0, rd_ptr_q} >= cell_cnt) ? '0 : rd_ptr_q;
  assign p_nxt      = {1'b0, p_clamp} + 9'd1;
  assign rd_ptr_nxt = (p_nxt >= cell_cnt) ? '0 : p_nxt[7:0];

  smsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.cell_begin && !use_order_q),
    .dividend_i (p_clamp),
    .divisor_i  (eff_cols),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      smp_q  <= sample_i;
      time_q <= current_time_i;
      oidx_q <= order_index_i;
      orow_q <= order_row_i;
      ocol_q <= order_col_i;
    end
  end

  always_comb begin
    ord_re    = 1'b0;
    ord_raddr = '0;
    if (cmd_i.do_start) begin
      ord_re = use_order_q;
    end else if (cmd_i.do_tick) begin
      ord_re    = active_q && use_order_q;
      ord_raddr = tick_idx;
    end else if (cmd_i.cell_begin) begin
      ord_re    = use_order_q;
      ord_raddr = p_clamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load) ord_mem[oidx_q] <= {orow_q, ocol_q};
    if (ord_re) ord_rdata_q <= ord_mem[ord_raddr];
  end

  assign fs_we    = cmd_i.do_tick && active_q;
  assign fs_waddr = {cur_row_q, cur_col_q};
  assign fs_re    = cmd_i.cell_from_ord || cmd_i.cell_from_div;
  assign fs_raddr = cmd_i.cell_from_ord ? ord_rdata_q : {div_quot[3:0], div_rem};
  assign cell_val = fs_rvld_q ? fs_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[fs_waddr] <= smp_q & SampleMask;
    if (fs_re) fs_rdata_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_vld_q  <= '0;
      fs_rvld_q <= 1'b0;
    end else begin
      if (fs_we) fs_vld_q[fs_waddr] <= 1'b1;
      if (fs_re) fs_rvld_q <= fs_vld_q[fs_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      scan_idx_q <= '0;
      rd_ptr_q   <= '0;
      active_q   <= 1'b0;
      complete_q <= 1'b0;
      stamp_q    <= '0;
    end else begin
      if (cmd_i.do_start) begin
        scan_idx_q <= '0;
        complete_q <= 1'b0;
        active_q   <= 1'b1;
        stamp_q    <= time_q;
        if (!use_order_q) begin
          cur_row_q <= '0;
          cur_col_q <= '0;
        end
      end
      if (cmd_i.do_tick && active_q) begin
        if (use_order_q) begin
          scan_idx_q <= tick_idx;
          if (ord_end) begin
            active_q   <= 1'b0;
            complete_q <= 1'b1;
          end
        end else if (col_wrap) begin
          cur_col_q <= '0;
          if (row_wrap) begin
            cur_row_q  <= '0;
            active_q   <= 1'b0;
            complete_q <= 1'b1;
          end else begin
            cur_row_q <= cur_row_q + 4'd1;
          end
        end else begin
          cur_col_q <= cur_col_q + 4'd1;
        end
      end
      if (cmd_i.cur_from_ord) begin
        cur_row_q <= ord_rdata_q[7:4];
        cur_col_q <= ord_rdata_q[3:0];
      end
      if (cmd_i.do_stop) active_q <= 1'b0;
      if (cmd_i.do_time) complete_q <= 1'b0;
      if (cmd_i.do_hdr) rd_ptr_q <= '0;
      if (cmd_i.cell_begin) rd_ptr_q <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_hdr) begin
      byte_q[0] <= mode_byte_q;
      if (hdr_len >= {1'b0, LenStep, 1'b0}) begin
        byte_q[1] <= LenStep;
        byte_q[2] <= LenStep;
        byte_q[3] <= 8'(hdr_len - {1'b0, LenStep, 1'b0});
        nbm1_q    <= 2'd3;
      end else if (hdr_len >= {2'b0, LenStep}) begin
        byte_q[1] <= LenStep;
        byte_q[2] <= 8'(hdr_len - {2'b0, LenStep});
        nbm1_q    <= 2'd2;
      end else begin
        byte_q[1] <= hdr_len[7:0];
        nbm1_q    <= 2'd1;
      end
    end else if (cmd_i.do_time) begin
      byte_q[0] <= elapsed[7:0];
      byte_q[1] <= elapsed[15:8];
      byte_q[2] <= elapsed[23:16];
      byte_q[3] <= elapsed[31:24];
      nbm1_q    <= 2'd3;
    end else if (cmd_i.cell_fin) begin
      byte_q[0] <= cell_val[7:0];
      byte_q[1] <= cell_val[15:8];
      nbm1_q    <= 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      byte_valid_o   <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
      byte_valid_o   <= cmd_i.emit && !cmd_i.blank;
      last_o         <= cmd_i.emit && cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mux_row_o    <= cur_row_q + first_row_q;
      mux_col_o    <= cur_col_q + first_col_q;
      scanning_o   <= active_q;
      frame_done_o <= complete_q;
      out_byte_o   <= cmd_i.blank ? '0 : byte_q[cmd_i.idx];
    end
  end

  assign sts_o.use_order = use_order_q;
  assign sts_o.active    = active_q;
  assign sts_o.nbm1      = nbm1_q;
  assign sts_o.div_done  = div_done;

  `SMSC_ASSERT_IMP(a_flags_exclusive, 1'b1, !(active_q && complete_q), "scan running with frame complete")
  `SMSC_ASSERT_IMP(a_byte_has_strobe, byte_valid_o || last_o, result_valid_o, "byte or last without strobe")
  `SMSC_ASSERT_NXT(a_tick_end_stops, cmd_i.do_tick && active_q && use_order_q && ord_end, !active_q && complete_q && scan_idx_q == '0, "order scan did not end on last cell")

endmodule

// ===== rtl/smsc_ctrl.sv =====
// Operation sequencer: accepts commands and steps the datapath through each one
`include "sensor_matrix_scan_controller_core_assert.svh"
module smsc_ctrl import smsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] operation_i,
  output logic       busy_o,
  input  smsc_sts_t  sts_i,
  output smsc_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StExec      = 3'd1;
  localparam logic [2:0] StOrdWait   = 3'd2;
  localparam logic [2:0] StDiv       = 3'd3;
  localparam logic [2:0] StFrameWait = 3'd4;
  localparam logic [2:0] StEmit      = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [1:0] k_q, k_d;
  logic       blank_q, blank_d;
  logic       emit_last;

  assign emit_last = blank_q || (k_q == sts_i.nbm1);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    k_d     = k_q;
    blank_d = blank_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          op_d      = operation_i;
          state_d   = StExec;
        end
      end
      StExec: begin
        k_d     = '0;
        blank_d = !(op_q == OpReadHdr || op_q == OpReadCell || op_q == OpReadTime);
        state_d = StEmit;
        case (op_q)
          OpStart: begin
            cmd_o.do_start = 1'b1;
            if (sts_i.use_order) state_d = StOrdWait;
          end
          OpTick: begin
            cmd_o.do_tick = 1'b1;
            if (sts_i.active && sts_i.use_order) state_d = StOrdWait;
          end
          OpStop:     cmd_o.do_stop = 1'b1;
          OpReadHdr:  cmd_o.do_hdr  = 1'b1;
          OpReadCell: begin
            cmd_o.cell_begin = 1'b1;
            state_d = sts_i.use_order ? StOrdWait : StDiv;
          end
          OpReadTime: cmd_o.do_time = 1'b1;
          OpLoadOrd:  cmd_o.do_load = 1'b1;
          default: ;
        endcase
      end
      StOrdWait: begin
        if (op_q == OpReadCell) begin
          cmd_o.cell_from_ord = 1'b1;
          state_d = StFrameWait;
        end else begin
          cmd_o.cur_from_ord = 1'b1;
          state_d = StEmit;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.cell_from_div = 1'b1;
          state_d = StFrameWait;
        end
      end
      StFrameWait: begin
        cmd_o.cell_fin = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit  = 1'b1;
        cmd_o.blank = blank_q;
        cmd_o.idx   = k_q;
        cmd_o.last  = emit_last;
        if (emit_last) state_d = StIdle;
        else k_d = k_q + 2'd1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpStop;
      k_q     <= '0;
      blank_q <= 1'b1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      k_q     <= k_d;
      blank_q <= blank_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  `SMSC_ASSERT_IMP(a_emit_in_range, state_q == StEmit && !blank_q, k_q <= sts_i.nbm1, "beat index past byte count")
  `SMSC_ASSERT_IMP(a_div_raster_only, state_q == StDiv, op_q == OpReadCell && !sts_i.use_order, "divider wait outside raster cell read")
  `SMSC_ASSERT_IMP(a_ord_wait_mode, state_q == StOrdWait, sts_i.use_order, "order table wait in raster mode")

endmodule

// ===== rtl/sensor_matrix_scan_controller_core.sv =====
// Top level of the sensor matrix scan controller
// An item is taken when start_i is high while busy_o is low. busy_o stays high until the
// item's final beat has been launched; each beat sits on the result ports for one cycle,
// flagged by result_valid_o, in the cycle after it is launched, so the final beat, marked by
// last_o, shows in the first cycle with busy_o low again. The receiver cannot stall, so
// every beat must be taken when shown. Each item passes an execute state and then emits its
// beats; an order-list start or an order-list tick of a running scan first waits for the
// order table read, and a cell read waits for the frame store read, in raster mode after an
// eight-step column divider has split the read pointer into row and column.
// Register writes are always ready and take effect at once; change them only when idle.
// The frame store reads as zero after reset and needs no clearing time.
module sensor_matrix_scan_controller_core import smsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] sample_i,
  input  logic [31:0] current_time_i,
  input  logic [7:0]  order_index_i,
  input  logic [3:0]  order_row_i,
  input  logic [3:0]  order_col_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [3:0]  mux_row_o,
  output logic [3:0]  mux_col_o,
  output logic        scanning_o,
  output logic        frame_done_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_o
);

  smsc_cmd_t cmd;
  smsc_sts_t sts;

  smsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smsc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .sample_i       (sample_i),
    .current_time_i (current_time_i),
    .order_index_i  (order_index_i),
    .order_row_i    (order_row_i),
    .order_col_i    (order_col_i),
    .result_valid_o (result_valid_o),
    .mux_row_o      (mux_row_o),
    .mux_col_o      (mux_col_o),
    .scanning_o     (scanning_o),
    .frame_done_o   (frame_done_o),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o)
  );

endmodule
